// ===== rtl/acmac_pkg.sv =====
// Shared types, constants and AES helper functions for the CMAC tag block.
// No dependencies; used by every module under rtl/ except acmac_checker.
package acmac_pkg;

    localparam int BlockBytes = 16;
    localparam int VbWidth    = 5;
    localparam int QueueDepth = 2;
    localparam logic [7:0] RbConst  = 8'h87;
    localparam logic [7:0] PadConst = 8'h80;
    localparam logic [0:0] CfgKeyHi = 1'b0;
    localparam logic [0:0] CfgKeyLo = 1'b1;

    // classified block handed from the front end to the engine
    typedef struct packed {
        logic [127:0] data;
        logic         is_last;
        logic         full;
    } blk_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUBKEY,
        ST_BLOCK
    } eng_state_t;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] tbl [256];
        tbl = '{
            8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
            8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
            8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
            8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
            8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
            8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
            8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
            8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
            8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
            8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
            8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
            8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
            8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
            8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
            8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
            8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        return tbl[x];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a 128-bit block sits in bits 127-8i .. 120-8i
    function automatic logic [127:0] round_fn(input logic [127:0] s, input logic last_rnd,
                                              input logic [127:0] rk);
        logic [7:0] b [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, all;
        logic [127:0] o;
        for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                t[r+4*c] = sbox(b[r+4*((c+r)%4)]);
        if (!last_rnd) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                all = a0 ^ a1 ^ a2 ^ a3;
                t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
                t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
                t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
                t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) o[127-8*i -: 8] = t[i];
        return o ^ rk;
    endfunction

    function automatic logic [127:0] next_rk(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        {w0, w1, w2, w3} = k;
        t = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    function automatic logic [127:0] dbl(input logic [127:0] x);
        return {x[126:0], 1'b0} ^ {120'd0, (x[127] ? RbConst : 8'h00)};
    endfunction

endpackage

// ===== rtl/acmac_front.sv =====
// Front end: accepts message blocks and applies padding / length classification.
// Depends on acmac_pkg; feeds acmac_queue.
module acmac_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [63:0]         s_data_hi,
    input  logic [63:0]         s_data_lo,
    input  logic [4:0]          s_valid_bytes,
    input  logic                s_last,
    input  logic                s_valid,
    output logic                s_ready,
    output acmac_pkg::blk_t     blk,
    output logic                blk_valid,
    input  logic                blk_ready
);
    acmac_pkg::blk_t blk_reg, blk_next;
    logic            vld_reg;
    logic [127:0]    raw, mask, pad;
    logic [4:0]      n;
    logic            full;

    assign s_ready = !vld_reg || blk_ready;

    always_comb begin
        raw  = {s_data_hi, s_data_lo};
        n    = (s_valid_bytes > 5'd16) ? 5'd16 : s_valid_bytes;
        full = !s_last || (n == 5'd16);
        mask = '0;
        pad  = '0;
        for (int i = 0; i < 16; i++) begin
            if (5'(i) < n) mask[127-8*i -: 8] = 8'hff;
            if (5'(i) == n) pad[127-8*i -: 8] = acmac_pkg::PadConst;
        end
        blk_next.data    = full ? raw : ((raw & mask) | pad);
        blk_next.is_last = s_last;
        blk_next.full    = full;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (s_ready) begin
            vld_reg <= s_valid;
        end
        if (s_valid && s_ready) blk_reg <= blk_next;
    end

    assign blk       = blk_reg;
    assign blk_valid = vld_reg;
endmodule

// ===== rtl/acmac_queue.sv =====
// Short FIFO between front end and engine so each side stalls independently.
// Depends on acmac_pkg.
module acmac_queue #(
    parameter int Depth = acmac_pkg::QueueDepth
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  acmac_pkg::blk_t wr_data,
    input  logic            wr_valid,
    output logic            wr_ready,
    output acmac_pkg::blk_t rd_data,
    output logic            rd_valid,
    input  logic            rd_ready
);
    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
    acmac_pkg::blk_t mem [Depth];
    logic [AW-1:0]   wp_reg, rp_reg;
    logic [AW:0]     cnt_reg;
    logic            wr, rd;

    assign wr_ready = cnt_reg != (AW+1)'(Depth);
    assign rd_valid = cnt_reg != '0;
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;
    assign rd_data = mem[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= (wp_reg == AW'(Depth-1)) ? '0 : wp_reg + 1'b1;
            if (rd) rp_reg <= (rp_reg == AW'(Depth-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr) - (AW+1)'(rd);
        end
        if (wr) mem[wp_reg] <= wr_data;
    end
endmodule

// ===== rtl/acmac_engine.sv =====
// Back end: iterative AES-128 round unit, subkey derivation and CBC chaining.
// Depends on acmac_pkg.
module acmac_engine (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [127:0]    key,
    input  logic            key_wr,
    input  acmac_pkg::blk_t blk,
    input  logic            blk_valid,
    output logic            blk_ready,
    output logic [63:0]     m_mac_hi,
    output logic [63:0]     m_mac_lo,
    output logic            m_valid,
    input  logic            m_ready
);
    acmac_pkg::eng_state_t st_reg, st_next;
    logic [127:0] s_reg, s_next, rk_reg, rk_next, cv_reg, cv_next;
    logic [127:0] k1_reg, k1_next, k2_reg, k2_next, out_reg, out_next, rnd, lv;
    logic [127:0] rk_rnd;
    logic [7:0]   rc_reg, rc_next;
    logic [3:0]   rnd_reg, rnd_next;
    logic         last_reg, last_next, ovld_reg, ovld_next, skr_reg, skr_next;
    logic         out_free;

    assign out_free  = !ovld_reg || m_ready;
    assign blk_ready = (st_reg == acmac_pkg::ST_IDLE) && skr_reg && out_free;
    assign rk_rnd    = acmac_pkg::next_rk(rk_reg, rc_reg);
    assign rnd       = acmac_pkg::round_fn(s_reg, rnd_reg == 4'd10, rk_rnd);

    always_comb begin
        st_next   = st_reg;
        s_next    = s_reg;
        rk_next   = rk_rnd;
        rc_next   = rc_reg;
        rnd_next  = rnd_reg;
        cv_next   = cv_reg;
        k1_next   = k1_reg;
        k2_next   = k2_reg;
        out_next  = out_reg;
        last_next = last_reg;
        ovld_next = ovld_reg && !m_ready;
        skr_next  = skr_reg && !key_wr;
        lv        = '0;
        unique case (st_reg)
            acmac_pkg::ST_IDLE: begin
                if (blk_valid && !skr_reg) begin
                    // encrypt zero to derive subkeys first
                    s_next   = key;
                    rk_next  = key;
                    rc_next  = 8'h01;
                    rnd_next = 4'd1;
                    st_next  = acmac_pkg::ST_SUBKEY;
                end else if (blk_valid && blk_ready) begin
                    lv = blk.data;
                    if (blk.is_last) lv = lv ^ (blk.full ? k1_reg : k2_reg);
                    s_next    = lv ^ cv_reg ^ key;
                    rk_next   = key;
                    rc_next   = 8'h01;
                    rnd_next  = 4'd1;
                    last_next = blk.is_last;
                    st_next   = acmac_pkg::ST_BLOCK;
                end
            end
            acmac_pkg::ST_SUBKEY, acmac_pkg::ST_BLOCK: begin
                s_next   = rnd;
                rc_next  = acmac_pkg::xtime(rc_reg);
                rnd_next = rnd_reg + 4'd1;
                if (rnd_reg == 4'd10) begin
                    st_next = acmac_pkg::ST_IDLE;
                    if (st_reg == acmac_pkg::ST_SUBKEY) begin
                        k1_next  = acmac_pkg::dbl(rnd);
                        k2_next  = acmac_pkg::dbl(acmac_pkg::dbl(rnd));
                        skr_next = !key_wr;
                    end else if (last_reg) begin
                        out_next  = rnd;
                        ovld_next = 1'b1;
                        cv_next   = '0;
                    end else begin
                        cv_next = rnd;
                    end
                end
            end
            default: st_next = acmac_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= acmac_pkg::ST_IDLE;
            ovld_reg <= 1'b0;
            skr_reg  <= 1'b0;
            cv_reg   <= '0;
        end else begin
            st_reg   <= st_next;
            ovld_reg <= ovld_next;
            skr_reg  <= skr_next;
            cv_reg   <= cv_next;
        end
        s_reg    <= s_next;
        rk_reg   <= rk_next;
        rc_reg   <= rc_next;
        rnd_reg  <= rnd_next;
        k1_reg   <= k1_next;
        k2_reg   <= k2_next;
        out_reg  <= out_next;
        last_reg <= last_next;
    end

    assign m_mac_hi = out_reg[127:64];
    assign m_mac_lo = out_reg[63:0];
    assign m_valid  = ovld_reg;
endmodule

// ===== rtl/aes_cmac_tag_top.sv =====
// AES-128 CMAC tag generator top level: key registers plus front/queue/engine.
// Depends on acmac_pkg, acmac_front, acmac_queue, acmac_engine.
//
// Usage: write the key through cfg_we/cfg_index/cfg_data (index 0 = key_hi,
// index 1 = key_lo) while the block is idle. Stream each message as 16-byte
// transactions on s_* (valid/ready); s_last marks the final block and
// s_valid_bytes gives its byte count (0..16). One tag per message appears
// on m_mac_hi/m_mac_lo with m_valid/m_ready.
// Timing: the engine runs one AES round per cycle; each block occupies it for
// a load plus ten rounds before the next block is taken. The first block
// after reset or a key write first waits while the engine derives the
// subkeys. The tag is registered when the last block's final round ends.
// The front end and a two-entry queue keep accepting while the engine works.
// Reset clears the chaining value, subkey-ready flag and all handshakes; the
// key resets to zero. If m_ready stays low, the finished tag is held and
// the engine stops before the next block, backing up the queue and s_ready.
module aes_cmac_tag_top #(
    parameter int QueueDepth = acmac_pkg::QueueDepth
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic [63:0] s_data_hi,
    input  logic [63:0] s_data_lo,
    input  logic [4:0]  s_valid_bytes,
    input  logic        s_last,
    input  logic        s_valid,
    output logic        s_ready,
    output logic [63:0] m_mac_hi,
    output logic [63:0] m_mac_lo,
    output logic        m_valid,
    input  logic        m_ready
);
    logic [63:0]     key_hi_reg, key_lo_reg;
    acmac_pkg::blk_t f_blk, q_blk;
    logic            f_valid, f_ready, q_valid, q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_hi_reg <= '0;
            key_lo_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                acmac_pkg::CfgKeyHi: key_hi_reg <= cfg_data;
                acmac_pkg::CfgKeyLo: key_lo_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    acmac_front u_front (
        .aclk, .aresetn, .s_data_hi, .s_data_lo, .s_valid_bytes, .s_last,
        .s_valid, .s_ready, .blk(f_blk), .blk_valid(f_valid), .blk_ready(f_ready)
    );

    acmac_queue #(.Depth(QueueDepth)) u_queue (
        .aclk, .aresetn, .wr_data(f_blk), .wr_valid(f_valid), .wr_ready(f_ready),
        .rd_data(q_blk), .rd_valid(q_valid), .rd_ready(q_ready)
    );

    acmac_engine u_engine (
        .aclk, .aresetn, .key({key_hi_reg, key_lo_reg}), .key_wr(cfg_we),
        .blk(q_blk), .blk_valid(q_valid), .blk_ready(q_ready),
        .m_mac_hi, .m_mac_lo, .m_valid, .m_ready
    );
endmodule

// ===== rtl/acmac_checker.sv =====
// Port-level checker for aes_cmac_tag_top, attached by bind.
// Depends only on the top level's ports.
module acmac_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_last,
    input logic [63:0] m_mac_hi,
    input logic [63:0] m_mac_lo,
    input logic        m_valid,
    input logic        m_ready
);
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_mac_hi) && $stable(m_mac_lo))
        else $error("tag changed while stalled");

    a_rst_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("tag valid after reset");

    a_s_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_last))
        else $error("input transaction dropped while stalled");

    a_m_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |=> !m_valid)
        else $error("tag repeated");
endmodule

bind aes_cmac_tag_top acmac_checker u_acmac_checker (
    .aclk, .aresetn, .s_valid, .s_ready, .s_last, .m_mac_hi, .m_mac_lo,
    .m_valid, .m_ready
);
